>>> rtl/rpak_pkg.sv
// Shared types and constants for the ranked precision at k block.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package rpak_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int NUM_CUTOFFS   = 4;
    localparam int SCORE_W       = 32;
    localparam int CUT_W         = 11;
    localparam int PREC_W        = 17;
    localparam int NUM_W         = CUT_W + 16;
    localparam int DCNT_W        = $clog2(NUM_W);
    localparam int CIDX_W        = 2;

    localparam logic [CIDX_W-1:0] REG_CUT_ONE   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_CUT_TWO   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_CUT_THREE = 2'd2;
    localparam logic [CIDX_W-1:0] REG_CUT_FOUR  = 2'd3;

    typedef struct packed {
        logic signed [SCORE_W-1:0] item_score;
        logic                      is_relevant;
        logic                      last_item;
    } t_in_item;

    typedef struct packed {
        logic [PREC_W-1:0] precision_one;
        logic [PREC_W-1:0] precision_two;
        logic [PREC_W-1:0] precision_three;
        logic [PREC_W-1:0] precision_four;
        logic [CUT_W-1:0]  items_in_topic;
        logic [CUT_W-1:0]  relevant_in_topic;
        logic              overflowed;
    } t_out_item;

    typedef struct packed {
        logic                      vld;
        logic signed [SCORE_W-1:0] score;
        logic                      rel;
    } t_entry;

endpackage

>>> rtl/rpak_cell.sv
// One cell of the sorting chain: holds one ranked entry.
// Depends on rpak_pkg.
`timescale 1ns / 1ps
module rpak_cell import rpak_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_ins,
    input  logic   i_drain,
    input  t_entry i_new,
    input  t_entry i_prev,
    input  logic   i_prev_keep,
    input  t_entry i_next,
    output t_entry o_ent,
    output logic   o_keep
);
    logic                      r_vld;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_rel;

    assign o_keep = r_vld && (r_score >= i_new.score);
    assign o_ent  = '{vld: r_vld, score: r_score, rel: r_rel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ins && !o_keep) begin
            r_vld <= i_prev_keep ? i_new.vld : i_prev.vld;
        end else if (i_drain) begin
            r_vld <= i_next.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins && !o_keep) begin
            r_score <= i_prev_keep ? i_new.score : i_prev.score;
            r_rel   <= i_prev_keep ? i_new.rel : i_prev.rel;
        end else if (i_drain) begin
            r_score <= i_next.score;
            r_rel   <= i_next.rel;
        end
    end
endmodule

>>> rtl/rpak_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rpak_pkg.
`timescale 1ns / 1ps
module rpak_div import rpak_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [CUT_W-1:0]  i_den,
    output logic              o_done,
    output logic [PREC_W-1:0] o_quo
);
    logic [CUT_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quo;
    logic [CUT_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [CUT_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_quo[PREC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DCNT_W'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? CUT_W'(w_trial - {1'b0, r_den}) : w_trial[CUT_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end
endmodule

>>> rtl/ranked_precision_at_k.sv
// Ranked precision at k: a chain of sorting cells plus a shared divider.
// Items other than the last of a topic are accepted without a stall; after the topic's
// last item the input stalls until its result is taken: the chain drains one entry
// a cycle, then the divider serves the four cutoffs in turn.
// Synchronous active-low reset clears all counts, cutoffs and cell valid bits.
`timescale 1ns / 1ps
module ranked_precision_at_k import rpak_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CUT_W-1:0]  i_cfg_data
);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int JW = $clog2(NUM_CUTOFFS);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_DRAIN = 4'b0010,
        S_DIV   = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [CUT_W-1:0]         r_cut [NUM_CUTOFFS];
    logic [CW-1:0]            r_count, r_relcnt, r_rank, r_acc;
    logic                     r_ovf;
    logic [CUT_W-1:0]         r_hit [NUM_CUTOFFS];
    logic [NUM_CUTOFFS-1:0]   r_found;
    logic [PREC_W-1:0]        r_prec [NUM_CUTOFFS];
    logic [JW-1:0]            r_j;
    logic                     r_start;
    logic                     r_oval;
    t_out_item                r_out;

    t_entry                   w_ent [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]     w_keep;
    t_entry                   w_new;
    logic                     w_acc_in, w_ins, w_drain, w_done;
    logic [PREC_W-1:0]        w_quo;
    logic [CW-1:0]            w_rank1, w_acc1;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;
    assign w_acc_in    = i_in_valid && !o_in_stall;
    assign w_ins       = w_acc_in && (r_count < CW'(MAX_ITEMS));
    assign w_drain     = (r_state == S_DRAIN);
    assign w_new       = '{vld: 1'b1, score: i_in_data.item_score,
                           rel: i_in_data.is_relevant};
    assign w_rank1     = r_rank + 1'b1;
    assign w_acc1      = r_acc + CW'(w_ent[0].rel);

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        rpak_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ins       (w_ins),
            .i_drain     (w_drain),
            .i_new       (w_new),
            .i_prev      ((g == 0) ? t_entry'('0) : w_ent[(g == 0) ? 0 : g-1]),
            .i_prev_keep ((g == 0) ? 1'b1 : w_keep[(g == 0) ? 0 : g-1]),
            .i_next      ((g == MAX_ITEMS-1) ? t_entry'('0)
                                             : w_ent[(g == MAX_ITEMS-1) ? g : g+1]),
            .o_ent       (w_ent[g]),
            .o_keep      (w_keep[g])
        );
    end

    rpak_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   ({r_hit[r_j], 16'b0}),
        .i_den   (r_cut[r_j]),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_acc_in && i_in_data.last_item) begin
                    if (w_ins || r_count != '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DRAIN: begin
                if (w_rank1 == r_count) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_done && r_j == JW'(NUM_CUTOFFS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_oval) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_relcnt <= '0;
            r_ovf    <= 1'b0;
            r_rank   <= '0;
            r_acc    <= '0;
            r_found  <= '0;
            r_j      <= '0;
            r_start  <= 1'b0;
            r_oval   <= 1'b0;
            for (int c = 0; c < NUM_CUTOFFS; c++) begin
                r_cut[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_start <= (n_state == S_DIV && r_state != S_DIV)
                    || (r_state == S_DIV && w_done && r_j != JW'(NUM_CUTOFFS - 1));
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_CUT_ONE:   r_cut[0] <= i_cfg_data;
                    REG_CUT_TWO:   r_cut[1] <= i_cfg_data;
                    REG_CUT_THREE: r_cut[2] <= i_cfg_data;
                    REG_CUT_FOUR:  r_cut[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_ins) begin
                r_count  <= r_count + 1'b1;
                r_relcnt <= r_relcnt + CW'(i_in_data.is_relevant);
            end else if (w_acc_in) begin
                r_ovf <= 1'b1;
            end
            if (n_state == S_DIV && r_state != S_DIV) begin
                r_j <= '0;
            end
            if (r_state == S_LOAD) begin
                r_rank  <= '0;
                r_acc   <= '0;
                r_found <= '0;
            end
            if (w_drain) begin
                r_rank <= w_rank1;
                r_acc  <= w_acc1;
                for (int c = 0; c < NUM_CUTOFFS; c++) begin
                    if ({{(32-CW){1'b0}}, w_rank1} == {{(32-CUT_W){1'b0}}, r_cut[c]}) begin
                        r_found[c] <= 1'b1;
                    end
                end
            end
            if (r_state == S_DIV && w_done && r_j != JW'(NUM_CUTOFFS - 1)) begin
                r_j <= r_j + 1'b1;
            end
            if (r_state == S_DIV && n_state == S_OUT) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_out_stall) begin
                r_oval   <= 1'b0;
                r_count  <= '0;
                r_relcnt <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            for (int c = 0; c < NUM_CUTOFFS; c++) begin
                r_hit[c] <= '0;
            end
        end else if (w_drain) begin
            for (int c = 0; c < NUM_CUTOFFS; c++) begin
                if ({{(32-CW){1'b0}}, w_rank1} == {{(32-CUT_W){1'b0}}, r_cut[c]}) begin
                    r_hit[c] <= CUT_W'(w_acc1);
                end
            end
        end
        if (r_state == S_DIV && w_done) begin
            r_prec[r_j] <= r_found[r_j] ? w_quo : '0;
        end
        if (r_state == S_DIV && n_state == S_OUT) begin
            r_out.precision_one     <= r_prec[0];
            r_out.precision_two     <= r_prec[1];
            r_out.precision_three   <= r_prec[2];
            r_out.precision_four    <= r_found[3] ? w_quo : '0;
            r_out.items_in_topic    <= CUT_W'(r_count);
            r_out.relevant_in_topic <= CUT_W'(r_relcnt);
            r_out.overflowed        <= r_ovf;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("Stored item count exceeds capacity.");
    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(r_count) == CW'(MAX_ITEMS))
        else $error("Overflow flagged while the chain had room.");
    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> (r_count == '0 && !o_out_valid))
        else $error("Topic state not cleared after the result transfer.");
    a_drained_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !w_ent[0].vld)
        else $error("Chain not empty after draining.");
`endif
endmodule

>>> test/testbench.sv
// Testbench for ranked_precision_at_k: random and directed topics checked against
// a behavioral ranking predictor. Depends on rpak_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
    import rpak_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic cfg_valid, cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CUT_W-1:0] cfg_data;
    t_in_item in_data;
    t_out_item out_data;

    ranked_precision_at_k i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    localparam int CAPACITY = MAX_ITEMS_DEF;
    localparam int STALL_LIMIT = 200000;

    t_in_item pending_items[$];
    t_out_item expected_scores[$];
    logic [CUT_W-1:0] cutoffs[NUM_CUTOFFS];
    logic signed [SCORE_W-1:0] ranked_score[CAPACITY];
    logic ranked_rel[CAPACITY];
    int ranked_count, relevant_total;
    logic dropped;
    int errors;
    int quiet_cycles;
    bit calm;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [PREC_W-1:0] precision_for(input int k);
        longint hits;
        hits = 0;
        if (k == 0 || k > ranked_count) return '0;
        for (int i = 0; i < k; i++) hits += ranked_rel[i];
        return PREC_W'((hits << 16) / k);
    endfunction

    task automatic enqueue_item(input t_in_item it);
        pending_items = {pending_items, it};
    endtask

    task automatic rank_item(input t_in_item it);
        t_out_item res;
        int pos;
        if (ranked_count < CAPACITY) begin
            pos = ranked_count;
            while (pos > 0 && ranked_score[pos-1] < it.item_score) begin
                ranked_score[pos] = ranked_score[pos-1];
                ranked_rel[pos] = ranked_rel[pos-1];
                pos--;
            end
            ranked_score[pos] = it.item_score;
            ranked_rel[pos] = it.is_relevant;
            ranked_count++;
            relevant_total += it.is_relevant;
        end else begin
            dropped = 1'b1;
        end
        if (it.last_item) begin
            res.precision_one = precision_for(cutoffs[0]);
            res.precision_two = precision_for(cutoffs[1]);
            res.precision_three = precision_for(cutoffs[2]);
            res.precision_four = precision_for(cutoffs[3]);
            res.items_in_topic = CUT_W'(ranked_count);
            res.relevant_in_topic = CUT_W'(relevant_total);
            res.overflowed = dropped;
            expected_scores = {expected_scores, res};
            ranked_count = 0;
            relevant_total = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic add_topic(input int n, input int score_span, input int rel_pct);
        t_in_item it;
        for (int i = 0; i < n; i++) begin
            if (score_span == 0) it.item_score = $urandom;
            else it.item_score = $signed($urandom_range(score_span)) - score_span / 2;
            it.is_relevant = ($urandom_range(99) < rel_pct);
            it.last_item = (i == n - 1);
            enqueue_item(it);
        end
    endtask

    task automatic write_cutoff(input logic [CIDX_W-1:0] idx, input int k);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CUT_W'(k);
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cutoffs[idx] = CUT_W'(k);
    endtask

    task automatic set_cutoffs(input int a, input int b, input int c, input int d);
        write_cutoff(REG_CUT_ONE, a);
        write_cutoff(REG_CUT_TWO, b);
        write_cutoff(REG_CUT_THREE, c);
        write_cutoff(REG_CUT_FOUR, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_phase();
        while (pending_items.size() != 0 || expected_scores.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Driver: applies pending items and ranks each one as its transfer completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                rank_item(in_data);
                void'(pending_items.pop_front());
            end
            if (in_valid && in_stall) begin
            end else if (pending_items.size() != 0
                         && (calm || $urandom_range(99) >= 14)) begin
                in_valid <= 1'b1;
                in_data <= pending_items[0];
            end else begin
                in_valid <= 1'b0;
                in_data <= t_in_item'($urandom);
            end
        end
    end

    // Monitor: compares every completed result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_scores.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_scores.pop_front();
                    if (out_data.precision_one !== want.precision_one)
                        report_mismatch("precision_one", out_data.precision_one,
                                        want.precision_one);
                    if (out_data.precision_two !== want.precision_two)
                        report_mismatch("precision_two", out_data.precision_two,
                                        want.precision_two);
                    if (out_data.precision_three !== want.precision_three)
                        report_mismatch("precision_three", out_data.precision_three,
                                        want.precision_three);
                    if (out_data.precision_four !== want.precision_four)
                        report_mismatch("precision_four", out_data.precision_four,
                                        want.precision_four);
                    if (out_data.items_in_topic !== want.items_in_topic)
                        report_mismatch("items_in_topic", out_data.items_in_topic,
                                        want.items_in_topic);
                    if (out_data.relevant_in_topic !== want.relevant_in_topic)
                        report_mismatch("relevant_in_topic", out_data.relevant_in_topic,
                                        want.relevant_in_topic);
                    if (out_data.overflowed !== want.overflowed)
                        report_mismatch("overflowed", out_data.overflowed, want.overflowed);
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 14);
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL ranked_precision_at_k");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_data = '0;
        errors = 0;
        calm = 1'b0;
        hold_left = 0;
        ranked_count = 0;
        relevant_total = 0;
        dropped = 1'b0;
        for (int i = 0; i < NUM_CUTOFFS; i++) cutoffs[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Cutoffs at reset are zero, so every precision is zero.
        add_topic(3, 0, 50);
        drain_phase();

        set_cutoffs(1, 2, 3, 5);
        // Extreme scores, ties in arrival order, and a lone item topic.
        it.item_score = 32'sh7FFFFFFF; it.is_relevant = 1'b0; it.last_item = 1'b0;
        enqueue_item(it);
        it.item_score = 32'sh80000000; it.is_relevant = 1'b1;
        enqueue_item(it);
        it.item_score = 32'sh7FFFFFFF; it.is_relevant = 1'b1;
        enqueue_item(it);
        it.item_score = '0; it.is_relevant = 1'b0;
        enqueue_item(it);
        it.item_score = '0; it.is_relevant = 1'b1; it.last_item = 1'b1;
        enqueue_item(it);
        it.item_score = -32'sd1; it.is_relevant = 1'b1; it.last_item = 1'b1;
        enqueue_item(it);
        add_topic(4, 6, 50);
        drain_phase();

        // Largest cutoffs, full store and dropped items, including a dropped last item.
        set_cutoffs(1024, 1023, 0, 7);
        add_topic(1026, 20, 60);
        add_topic(3, 0, 100);
        drain_phase();

        // Long receiver hold-off so the block backs up its input.
        set_cutoffs(2, 4, 8, 16);
        hold_left = 600;
        for (int t = 0; t < 10; t++) add_topic($urandom_range(1, 12), 8, 50);
        drain_phase();

        for (int phase = 0; phase < 6; phase++) begin
            set_cutoffs($urandom_range(0, 12), $urandom_range(1, 40),
                        $urandom_range(0, 1024), $urandom_range(1, 6));
            calm = (phase == 3);
            for (int t = 0; t < 5; t++)
                add_topic($urandom_range(1, 14), ($urandom_range(1) ? 0 : 10),
                          $urandom_range(0, 100));
            drain_phase();
        end
        calm = 1'b0;

        if (errors == 0) begin
            $display("PASS ranked_precision_at_k");
        end else begin
            $display("FAIL ranked_precision_at_k");
        end
        $finish;
    end
endmodule
